### rtl/adler32_pkg.sv
// Package for the streaming Adler-32 checksum block.
// Holds the modulus, the field widths and the queue entry type.
// It depends on nothing else and is imported by every module of the block.
package adler32_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned BSUM_W    = 10;
    localparam int unsigned WSUM_W    = 13;
    localparam int unsigned PROD_W    = 19;
    localparam int unsigned HACC_W    = 20;
    localparam int unsigned LANE_MAX  = 4;
    localparam int unsigned COUNT_MAX = 7;
    localparam int unsigned S_TDATA_W = 40;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SUM_W-1:0]  LOW_INIT  = 16'd1;
    localparam logic [SUM_W-1:0]  HIGH_INIT = 16'd0;
    localparam logic [SUM_W:0]    ADLER_MOD = 17'd65521;
    localparam logic [SUM_W:0]    FOLD_K    = 17'd15;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BSUM_W-1:0]  byte_sum;
        logic [WSUM_W-1:0]  weight_sum;
        logic               first;
        logic               last;
    } entry_t;

    // Reduces a value below 9 * 65521 using 2^16 = 15 (mod 65521).
    function automatic logic [SUM_W-1:0] fold_mod(input logic [HACC_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x[SUM_W-1:0]} + (FOLD_K * {13'd0, x[HACC_W-1:SUM_W]});
        if (t >= ADLER_MOD) begin
            t = t - ADLER_MOD;
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

### rtl/adler32_front.sv
// Front part of the Adler-32 block: accepts input words and condenses each
// into a byte count, a byte sum and a position-weighted byte sum.
// Depends on adler32_pkg.
module adler32_front #(
    parameter int unsigned BYTES_PER_ITEM = 4
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adler32_pkg::DATA_W-1:0]  data_bytes,
    input  logic [adler32_pkg::COUNT_W-1:0] byte_count,
    input  logic                            first,
    input  logic                            last,
    input  logic                            queue_full,
    output logic                            push,
    output adler32_pkg::entry_t             entry
);
    import adler32_pkg::*;

    localparam int unsigned CAP   = (BYTES_PER_ITEM < COUNT_MAX) ? BYTES_PER_ITEM : COUNT_MAX;
    localparam int unsigned LANES = (BYTES_PER_ITEM < LANE_MAX) ? BYTES_PER_ITEM : LANE_MAX;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

    logic [COUNT_W-1:0] count_sat;
    logic [BSUM_W-1:0]  bsum;
    logic [WSUM_W-1:0]  wsum;

    assign s_tready  = !queue_full;
    assign push      = s_tvalid && !queue_full;
    assign count_sat = (byte_count > CAP_C) ? CAP_C : byte_count;

    always_comb begin
        logic [7:0]         lane_byte;
        logic [COUNT_W-1:0] weight;
        bsum      = '0;
        wsum      = '0;
        lane_byte = '0;
        weight    = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_byte = data_bytes[8*i +: 8];
            if (count_sat > COUNT_W'(i)) begin
                weight = count_sat - COUNT_W'(i);
                bsum   = bsum + BSUM_W'(lane_byte);
                wsum   = wsum + WSUM_W'(weight * lane_byte);
            end
        end
    end

    always_comb begin
        entry.count      = count_sat;
        entry.byte_sum   = bsum;
        entry.weight_sum = wsum;
        entry.first      = first;
        entry.last       = last;
    end

endmodule

### rtl/adler32_queue.sv
// Short queue between the front and back parts of the Adler-32 block.
// Two entries, one write and one read port, registered state.
// Depends on adler32_pkg.
module adler32_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  adler32_pkg::entry_t push_entry,
    input  logic                pop,
    output logic                q_valid,
    output logic                q_full,
    output adler32_pkg::entry_t q_entry
);
    import adler32_pkg::*;

    entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/adler32_back.sv
// Back part of the Adler-32 block: folds one queued word per cycle into the
// two running sums, stalling a last word while a held checksum waits,
// and holds the checksum in an output register. Depends on adler32_pkg.
module adler32_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  adler32_pkg::entry_t            q_entry,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [adler32_pkg::DATA_W-1:0] m_tdata
);
    import adler32_pkg::*;

    logic [SUM_W-1:0]  low_reg, low_next;
    logic [SUM_W-1:0]  high_reg, high_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic [SUM_W-1:0]  low_base, high_base;
    logic [SUM_W:0]    low_acc;
    logic [PROD_W-1:0] prod;
    logic [HACC_W-1:0] high_acc;

    assign pop = q_valid && (!q_entry.last || !out_valid_reg || m_tready);

    assign low_base  = q_entry.first ? LOW_INIT : low_reg;
    assign high_base = q_entry.first ? HIGH_INIT : high_reg;
    assign low_acc   = {1'b0, low_base} + (SUM_W+1)'(q_entry.byte_sum);
    assign prod      = PROD_W'(q_entry.count) * PROD_W'(low_base);
    assign high_acc  = HACC_W'(high_base) + HACC_W'(prod) + HACC_W'(q_entry.weight_sum);

    always_comb begin
        low_next       = low_reg;
        high_next      = high_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop) begin
            low_next  = (low_acc >= ADLER_MOD) ? SUM_W'(low_acc - ADLER_MOD) : low_acc[SUM_W-1:0];
            high_next = fold_mod(high_acc);
            if (q_entry.last) begin
                out_valid_next = 1'b1;
                out_data_next  = {high_next, low_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg       <= LOW_INIT;
            high_reg      <= HIGH_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/adler32_checksum.sv
// Streaming Adler-32 checksum, one input word per cycle unless a held checksum backs up the queue.
// Path: each accepted word is written into the queue; the back part pops it and registers the checksum of a last word.
// Throughput: one word per cycle, set by the sum update in the back part; a held
// checksum stalls only the next last word, and s_tready drops once the two-entry queue fills.
// Reset (aresetn low, synchronous): queue emptied, output invalid, sums low=1 high=0.
// Depends on adler32_pkg, adler32_front, adler32_queue and adler32_back.
module adler32_checksum #(
    parameter int unsigned BYTES_PER_ITEM = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adler32_pkg::S_TDATA_W-1:0] s_tdata,  // data_bytes[31:0], byte_count[34:32], zeros
    input  logic                              s_tuser,  // first
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adler32_pkg::DATA_W-1:0]    m_tdata   // checksum[31:0]
);
    import adler32_pkg::*;

    logic   push, pop, q_valid, q_full;
    entry_t push_entry, q_entry;

    adler32_front #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .data_bytes (s_tdata[DATA_W-1:0]),
        .byte_count (s_tdata[DATA_W +: COUNT_W]),
        .first      (s_tuser),
        .last       (s_tlast),
        .queue_full (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    adler32_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_entry    (q_entry)
    );

    adler32_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/adler32_checker.sv
// Port-level checks for the Adler-32 block and the bind that attaches them.
// Depends on adler32_pkg and the adler32_checksum top level.
module adler32_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [adler32_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                              s_tuser,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [adler32_pkg::DATA_W-1:0]    m_tdata
);
    import adler32_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser)
            && $stable(s_tlast))
        else $error("Input word changed while it waited.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Checksum word dropped before it was taken.");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Reset did not empty the block.");

    a_low_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {1'b0, m_tdata[SUM_W-1:0]} < ADLER_MOD)
        else $error("Low sum not reduced.");

    a_high_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {1'b0, m_tdata[DATA_W-1:SUM_W]} < ADLER_MOD)
        else $error("High sum not reduced.");

endmodule

bind adler32_checksum adler32_checker u_adler32_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
